/* rtl/core/ecsm_pkg.sv */
// Shared types, constants and microcode for the elliptic-curve scalar multiplier.
// Used by the divider, datapath, controller, top level and checker.
`default_nettype none

package ecsm_pkg;

   localparam int FIELD_BITS     = 16;
   localparam int SCALAR_BITS    = 32;
   localparam int DIV_BITS       = 2 * FIELD_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_BITS + 1);
   localparam int COEF_BITS      = FIELD_BITS + 2;
   localparam int PROD_BITS      = 2 * FIELD_BITS + 3;
   localparam int UPC_BITS       = 5;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [FIELD_BITS-1:0] felem_type;

   localparam felem_type PRIME_RESET   = FIELD_BITS'(9739);
   localparam felem_type CURVE_A_RESET = FIELD_BITS'(497);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIELD_PRIME = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURVE_A     = 1'b1;

   // working register codes
   localparam logic [3:0] R_AX  = 4'd0;
   localparam logic [3:0] R_AY  = 4'd1;
   localparam logic [3:0] R_DX  = 4'd2;
   localparam logic [3:0] R_DY  = 4'd3;
   localparam logic [3:0] R_SX  = 4'd4;
   localparam logic [3:0] R_SY  = 4'd5;
   localparam logic [3:0] R_TX  = 4'd6;
   localparam logic [3:0] R_TY  = 4'd7;
   localparam logic [3:0] R_T0  = 4'd8;
   localparam logic [3:0] R_T1  = 4'd9;
   localparam logic [3:0] R_T2  = 4'd10;
   localparam logic [3:0] R_LAM = 4'd11;
   localparam logic [3:0] R_AR  = 4'd12;

   // datapath commands
   localparam logic [4:0] OP_NOP    = 5'd0;
   localparam logic [4:0] OP_LOAD   = 5'd1;
   localparam logic [4:0] OP_MODA   = 5'd2;
   localparam logic [4:0] OP_RWB    = 5'd3;
   localparam logic [4:0] OP_SHIFTK = 5'd4;
   localparam logic [4:0] OP_COPYD  = 5'd5;
   localparam logic [4:0] OP_LDST   = 5'd6;
   localparam logic [4:0] OP_SETINF = 5'd7;
   localparam logic [4:0] OP_WRES   = 5'd8;
   localparam logic [4:0] OP_ADD    = 5'd9;
   localparam logic [4:0] OP_SUB    = 5'd10;
   localparam logic [4:0] OP_MULS   = 5'd11;
   localparam logic [4:0] OP_IINIT  = 5'd12;
   localparam logic [4:0] OP_IDIV   = 5'd13;
   localparam logic [4:0] OP_IMUL   = 5'd14;
   localparam logic [4:0] OP_IUPD   = 5'd15;
   localparam logic [4:0] OP_IFIN   = 5'd16;
   localparam logic [4:0] OP_OUT    = 5'd17;

   // microcode operations
   localparam logic [2:0] U_ADD  = 3'd0;
   localparam logic [2:0] U_SUB  = 3'd1;
   localparam logic [2:0] U_MUL  = 3'd2;
   localparam logic [2:0] U_INV  = 3'd3;
   localparam logic [2:0] U_TAIL = 3'd4;
   localparam logic [2:0] U_END  = 3'd5;

   localparam logic [UPC_BITS-1:0] UPC_CHORD  = UPC_BITS'(0);
   localparam logic [UPC_BITS-1:0] UPC_TAIL   = UPC_BITS'(4);
   localparam logic [UPC_BITS-1:0] UPC_DOUBLE = UPC_BITS'(11);

   typedef struct packed {
      logic [31:0] scalar;
      felem_type   point_x;
      felem_type   point_y;
      logic        point_infinity;
   } req_type;

   typedef struct packed {
      felem_type result_x;
      felem_type result_y;
      logic      result_infinity;
      logic      range_error;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      logic [3:0] dst;
      logic [3:0] s1;
      logic [3:0] s2;
      logic       to_acc;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic range_err;
      logic acc_inf;
      logic dbl_inf;
      logic k_zero;
      logic k_lsb;
      logic xeq;
      logic yneg;
      logic r1_zero;
   } status_type;

   typedef struct packed {
      logic [2:0] uop;
      logic [3:0] dst;
      logic [3:0] s1;
      logic [3:0] s2;
   } uinstr_type;

   // Point addition program: chord slope, shared tail, then tangent slope.
   function automatic uinstr_type ucode(input logic [UPC_BITS-1:0] pc);
      uinstr_type ui;
      case (pc)
         5'd0:    ui = '{U_SUB, R_T1, R_TY, R_SY};
         5'd1:    ui = '{U_SUB, R_T2, R_TX, R_SX};
         5'd2:    ui = '{U_INV, R_T2, R_T2, R_T2};
         5'd3:    ui = '{U_MUL, R_LAM, R_T1, R_T2};
         5'd4:    ui = '{U_MUL, R_T0, R_LAM, R_LAM};
         5'd5:    ui = '{U_SUB, R_T0, R_T0, R_SX};
         5'd6:    ui = '{U_SUB, R_T0, R_T0, R_TX};
         5'd7:    ui = '{U_SUB, R_T1, R_SX, R_T0};
         5'd8:    ui = '{U_MUL, R_T1, R_LAM, R_T1};
         5'd9:    ui = '{U_SUB, R_T1, R_T1, R_SY};
         5'd10:   ui = '{U_END, R_T0, R_T0, R_T0};
         5'd11:   ui = '{U_MUL, R_T0, R_SX, R_SX};
         5'd12:   ui = '{U_ADD, R_T1, R_T0, R_T0};
         5'd13:   ui = '{U_ADD, R_T1, R_T1, R_T0};
         5'd14:   ui = '{U_ADD, R_T1, R_T1, R_AR};
         5'd15:   ui = '{U_ADD, R_T2, R_SY, R_SY};
         5'd16:   ui = '{U_INV, R_T2, R_T2, R_T2};
         5'd17:   ui = '{U_MUL, R_LAM, R_T1, R_T2};
         5'd18:   ui = '{U_TAIL, R_T0, R_T0, R_T0};
         default: ui = '{U_END, R_T0, R_T0, R_T0};
      endcase
      return ui;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ec_point_scalar_multiply_top.sv */
// Top level of the affine elliptic-curve scalar multiplier.
// Depends on ecsm_pkg, ecsm_ctrl and ecsm_datapath.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes one request: scalar k and
//    point P; rsp channel returns k*P with infinity and range-error flags.
//  - csr port writes field_prime (index 0) and curve_a (index 1); the user must
//    write them only while idle, which the block itself does not enforce.
//  - One request is worked at a time; req_ready is high only while idle.
//  - Infinity or out-of-range inputs skip the point arithmetic. Otherwise each
//    scalar bit up to the highest set bit costs one doubling, plus one addition
//    for each set bit. A point operation runs three or four modular multiplies
//    and one inverse by the Euclid loop, all on the shared bit-serial divider.
//  - The result sits in an output register; when the receiver stalls, the
//    finished request waits there and the next result waits for it to drain.
//  - Synchronous reset returns field_prime to 9739, curve_a to 497, drops any
//    request in flight and clears rsp_valid.
`default_nettype none

module ec_point_scalar_multiply_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire ecsm_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output ecsm_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [ecsm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire ecsm_pkg::felem_type                 csr_wdata
);

   ecsm_pkg::cmd_type    cmd;
   ecsm_pkg::status_type status;

   ecsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecsm_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/ecsm_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ecsm_pkg for widths.
`default_nettype none

module ecsm_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ecsm_pkg::DIV_BITS-1:0]  dividend,
   input  wire ecsm_pkg::felem_type            divisor,
   output logic                                busy,
   output logic [ecsm_pkg::DIV_BITS-1:0]       quotient,
   output ecsm_pkg::felem_type                 remainder
);

   logic [ecsm_pkg::DIV_BITS-1:0]     num_ff, num_in;
   ecsm_pkg::felem_type               rem_ff, rem_in;
   ecsm_pkg::felem_type               dsr_ff, dsr_in;
   logic [ecsm_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic [ecsm_pkg::FIELD_BITS:0]     trial;
   logic [ecsm_pkg::FIELD_BITS:0]     diff;

   always_comb begin
      trial   = {rem_ff, num_ff[ecsm_pkg::DIV_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = ecsm_pkg::DIV_CNT_BITS'(ecsm_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[ecsm_pkg::FIELD_BITS-1:0];
            num_in = {num_ff[ecsm_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[ecsm_pkg::FIELD_BITS-1:0];
            num_in = {num_ff[ecsm_pkg::DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ecsm_pkg::DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/core/ecsm_datapath.sv */
// Datapath: configuration, point registers, modular add/sub, Euclid inverse state,
// result register. Depends on ecsm_pkg and ecsm_divider.
`default_nettype none

module ecsm_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [ecsm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire ecsm_pkg::felem_type                   csr_wdata,
   input  wire ecsm_pkg::req_type                     req_data,
   input  wire ecsm_pkg::cmd_type                     cmd,
   output ecsm_pkg::status_type                       status,
   output ecsm_pkg::rsp_type                          rsp_data
);

   localparam int F = ecsm_pkg::FIELD_BITS;

   ecsm_pkg::felem_type p_ff, a_ff;
   logic [ecsm_pkg::SCALAR_BITS-1:0] k_ff, k_in;
   ecsm_pkg::felem_type px_ff, px_in, py_ff, py_in;
   logic pinf_ff, pinf_in;
   ecsm_pkg::felem_type ax_ff, ax_in, ay_ff, ay_in, dx_ff, dx_in, dy_ff, dy_in;
   ecsm_pkg::felem_type sx_ff, sx_in, sy_ff, sy_in, tx_ff, tx_in, ty_ff, ty_in;
   ecsm_pkg::felem_type t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   ecsm_pkg::felem_type lam_ff, lam_in, ar_ff, ar_in;
   logic acc_inf_ff, acc_inf_in, dbl_inf_ff, dbl_inf_in;
   ecsm_pkg::felem_type r0_ff, r0_in, r1_ff, r1_in;
   logic signed [ecsm_pkg::COEF_BITS-1:0] c0_ff, c0_in, c1_ff, c1_in;
   logic signed [ecsm_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   ecsm_pkg::rsp_type rsp_ff, rsp_in;

   ecsm_pkg::felem_type opa, opb, wdata;
   logic                wen;
   logic [F:0]          sum, sum_red, sub_res, ysum;
   logic signed [ecsm_pkg::COEF_BITS-1:0] c0_adj;
   logic                div_start, div_busy;
   logic [ecsm_pkg::DIV_BITS-1:0] div_dividend, div_quot;
   ecsm_pkg::felem_type div_divisor, div_rem;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= ecsm_pkg::PRIME_RESET;
         a_ff <= ecsm_pkg::CURVE_A_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ecsm_pkg::CSR_FIELD_PRIME: p_ff <= csr_wdata;
            ecsm_pkg::CSR_CURVE_A:     a_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.s1)
         ecsm_pkg::R_AX:  opa = ax_ff;
         ecsm_pkg::R_AY:  opa = ay_ff;
         ecsm_pkg::R_DX:  opa = dx_ff;
         ecsm_pkg::R_DY:  opa = dy_ff;
         ecsm_pkg::R_SX:  opa = sx_ff;
         ecsm_pkg::R_SY:  opa = sy_ff;
         ecsm_pkg::R_TX:  opa = tx_ff;
         ecsm_pkg::R_TY:  opa = ty_ff;
         ecsm_pkg::R_T0:  opa = t0_ff;
         ecsm_pkg::R_T1:  opa = t1_ff;
         ecsm_pkg::R_T2:  opa = t2_ff;
         ecsm_pkg::R_LAM: opa = lam_ff;
         ecsm_pkg::R_AR:  opa = ar_ff;
         default:         opa = '0;
      endcase
      case (cmd.s2)
         ecsm_pkg::R_AX:  opb = ax_ff;
         ecsm_pkg::R_AY:  opb = ay_ff;
         ecsm_pkg::R_DX:  opb = dx_ff;
         ecsm_pkg::R_DY:  opb = dy_ff;
         ecsm_pkg::R_SX:  opb = sx_ff;
         ecsm_pkg::R_SY:  opb = sy_ff;
         ecsm_pkg::R_TX:  opb = tx_ff;
         ecsm_pkg::R_TY:  opb = ty_ff;
         ecsm_pkg::R_T0:  opb = t0_ff;
         ecsm_pkg::R_T1:  opb = t1_ff;
         ecsm_pkg::R_T2:  opb = t2_ff;
         ecsm_pkg::R_LAM: opb = lam_ff;
         ecsm_pkg::R_AR:  opb = ar_ff;
         default:         opb = '0;
      endcase
   end

   // operands are below p, so one conditional subtract or add reduces
   assign sum     = {1'b0, opa} + {1'b0, opb};
   assign sum_red = (sum >= {1'b0, p_ff}) ? sum - {1'b0, p_ff} : sum;
   assign sub_res = (opa >= opb) ? {1'b0, opa} - {1'b0, opb}
                                 : {1'b0, opa} + {1'b0, p_ff} - {1'b0, opb};
   assign ysum    = {1'b0, sy_ff} + {1'b0, ty_ff};
   assign c0_adj  = (c0_ff < 0) ? c0_ff + $signed({2'b00, p_ff}) : c0_ff;

   assign div_start = (cmd.op == ecsm_pkg::OP_MULS) || (cmd.op == ecsm_pkg::OP_MODA)
                   || (cmd.op == ecsm_pkg::OP_IDIV);

   always_comb begin
      case (cmd.op)
         ecsm_pkg::OP_MULS: div_dividend = opa * opb;
         ecsm_pkg::OP_MODA: div_dividend = {{F{1'b0}}, a_ff};
         ecsm_pkg::OP_IDIV: div_dividend = {{F{1'b0}}, r0_ff};
         default:           div_dividend = '0;
      endcase
      div_divisor = (cmd.op == ecsm_pkg::OP_IDIV) ? r1_ff : p_ff;
   end

   ecsm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      k_in = k_ff;   px_in = px_ff;   py_in = py_ff;   pinf_in = pinf_ff;
      ax_in = ax_ff; ay_in = ay_ff;   dx_in = dx_ff;   dy_in = dy_ff;
      sx_in = sx_ff; sy_in = sy_ff;   tx_in = tx_ff;   ty_in = ty_ff;
      t0_in = t0_ff; t1_in = t1_ff;   t2_in = t2_ff;   lam_in = lam_ff;
      ar_in = ar_ff;
      acc_inf_in = acc_inf_ff;
      dbl_inf_in = dbl_inf_ff;
      r0_in = r0_ff; r1_in = r1_ff;   c0_in = c0_ff;   c1_in = c1_ff;
      prod_in = prod_ff;
      rsp_in  = rsp_ff;
      wen     = 1'b0;
      wdata   = '0;
      case (cmd.op)
         ecsm_pkg::OP_LOAD: begin
            k_in       = req_data.scalar[ecsm_pkg::SCALAR_BITS-1:0];
            px_in      = req_data.point_x;
            py_in      = req_data.point_y;
            pinf_in    = req_data.point_infinity;
            dx_in      = req_data.point_x;
            dy_in      = req_data.point_y;
            dbl_inf_in = req_data.point_infinity;
            acc_inf_in = 1'b1;
         end
         ecsm_pkg::OP_RWB: begin
            wen   = 1'b1;
            wdata = div_rem;
         end
         ecsm_pkg::OP_SHIFTK: k_in = k_ff >> 1;
         ecsm_pkg::OP_COPYD: begin
            ax_in      = dx_ff;
            ay_in      = dy_ff;
            acc_inf_in = dbl_inf_ff;
         end
         ecsm_pkg::OP_LDST: begin
            sx_in = cmd.to_acc ? ax_ff : dx_ff;
            sy_in = cmd.to_acc ? ay_ff : dy_ff;
            tx_in = dx_ff;
            ty_in = dy_ff;
         end
         ecsm_pkg::OP_SETINF: begin
            if (cmd.to_acc) begin
               acc_inf_in = 1'b1;
            end else begin
               dbl_inf_in = 1'b1;
            end
         end
         ecsm_pkg::OP_WRES: begin
            if (cmd.to_acc) begin
               ax_in = t0_ff;  ay_in = t1_ff;  acc_inf_in = 1'b0;
            end else begin
               dx_in = t0_ff;  dy_in = t1_ff;  dbl_inf_in = 1'b0;
            end
         end
         ecsm_pkg::OP_ADD: begin
            wen   = 1'b1;
            wdata = sum_red[F-1:0];
         end
         ecsm_pkg::OP_SUB: begin
            wen   = 1'b1;
            wdata = sub_res[F-1:0];
         end
         ecsm_pkg::OP_IINIT: begin
            r0_in = p_ff;
            r1_in = opa;
            c0_in = '0;
            c1_in = ecsm_pkg::COEF_BITS'(1);
         end
         ecsm_pkg::OP_IMUL: prod_in = $signed({1'b0, div_quot[F-1:0]}) * c1_ff;
         ecsm_pkg::OP_IUPD: begin
            c0_in = c1_ff;
            c1_in = c0_ff - prod_ff[ecsm_pkg::COEF_BITS-1:0];
            r0_in = r1_ff;
            r1_in = div_rem;
         end
         ecsm_pkg::OP_IFIN: begin
            wen   = 1'b1;
            wdata = (r0_ff == F'(1)) ? c0_adj[F-1:0] : '0;
         end
         ecsm_pkg::OP_OUT: begin
            if (status.range_err) begin
               rsp_in = '{'0, '0, 1'b1, 1'b1};
            end else if (acc_inf_ff) begin
               rsp_in = '{'0, '0, 1'b1, 1'b0};
            end else begin
               rsp_in = '{ax_ff, ay_ff, 1'b0, 1'b0};
            end
         end
         default: ;
      endcase
      if (wen) begin
         case (cmd.dst)
            ecsm_pkg::R_T0:  t0_in  = wdata;
            ecsm_pkg::R_T1:  t1_in  = wdata;
            ecsm_pkg::R_T2:  t2_in  = wdata;
            ecsm_pkg::R_LAM: lam_in = wdata;
            ecsm_pkg::R_AR:  ar_in  = wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;   px_ff <= px_in;   py_ff <= py_in;   pinf_ff <= pinf_in;
      ax_ff <= ax_in; ay_ff <= ay_in;   dx_ff <= dx_in;   dy_ff <= dy_in;
      sx_ff <= sx_in; sy_ff <= sy_in;   tx_ff <= tx_in;   ty_ff <= ty_in;
      t0_ff <= t0_in; t1_ff <= t1_in;   t2_ff <= t2_in;   lam_ff <= lam_in;
      ar_ff <= ar_in;
      acc_inf_ff <= acc_inf_in;
      dbl_inf_ff <= dbl_inf_in;
      r0_ff <= r0_in; r1_ff <= r1_in;   c0_ff <= c0_in;   c1_ff <= c1_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      status.div_busy  = div_busy;
      status.range_err = !pinf_ff && ((px_ff >= p_ff) || (py_ff >= p_ff));
      status.acc_inf   = acc_inf_ff;
      status.dbl_inf   = dbl_inf_ff;
      status.k_zero    = (k_ff == '0);
      status.k_lsb     = k_ff[0];
      status.xeq       = (sx_ff == tx_ff);
      status.yneg      = (ysum == '0) || (ysum == {1'b0, p_ff});
      status.r1_zero   = (r1_ff == '0);
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/ecsm_ctrl.sv */
// Controller: scalar bit loop, point-addition case split, microcode sequencing,
// Euclid loop and result handshake. Depends on ecsm_pkg.
`default_nettype none

module ecsm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ecsm_pkg::status_type status,
   output ecsm_pkg::cmd_type         cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_AWAIT  = 4'd2;
   localparam logic [3:0] S_BIT    = 4'd3;
   localparam logic [3:0] S_PA     = 4'd4;
   localparam logic [3:0] S_CASE   = 4'd5;
   localparam logic [3:0] S_EXEC   = 4'd6;
   localparam logic [3:0] S_MWAIT  = 4'd7;
   localparam logic [3:0] S_ICHK   = 4'd8;
   localparam logic [3:0] S_IWAIT  = 4'd9;
   localparam logic [3:0] S_IUPD   = 4'd10;
   localparam logic [3:0] S_NEXT   = 4'd11;
   localparam logic [3:0] S_FINISH = 4'd12;

   logic [3:0]                     state_ff, state_in;
   logic [ecsm_pkg::UPC_BITS-1:0]  upc_ff, upc_in;
   logic                           add_mode_ff, add_mode_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ecsm_pkg::uinstr_type           ui;

   assign ui = ecsm_pkg::ucode(upc_ff);

   always_comb begin
      state_in     = state_ff;
      upc_in       = upc_ff;
      add_mode_in  = add_mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.to_acc   = add_mode_ff;
      cmd.dst      = ui.dst;
      cmd.s1       = ui.s1;
      cmd.s2       = ui.s2;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ecsm_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.range_err || status.dbl_inf || status.acc_inf && status.k_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.op   = ecsm_pkg::OP_MODA;
               state_in = S_AWAIT;
            end
         end
         S_AWAIT: begin
            if (!status.div_busy) begin
               cmd.op   = ecsm_pkg::OP_RWB;
               cmd.dst  = ecsm_pkg::R_AR;
               state_in = S_BIT;
            end
         end
         S_BIT: begin
            // stop once no set bits remain: the doubled point no longer matters
            if (status.k_zero) begin
               state_in = S_FINISH;
            end else begin
               add_mode_in = status.k_lsb;
               state_in    = S_PA;
            end
         end
         S_PA: begin
            if (add_mode_ff && status.acc_inf) begin
               cmd.op   = ecsm_pkg::OP_COPYD;
               state_in = S_NEXT;
            end else if (status.dbl_inf) begin
               state_in = S_NEXT;
            end else begin
               cmd.op   = ecsm_pkg::OP_LDST;
               state_in = S_CASE;
            end
         end
         S_CASE: begin
            if (status.xeq && status.yneg) begin
               cmd.op   = ecsm_pkg::OP_SETINF;
               state_in = S_NEXT;
            end else begin
               upc_in   = status.xeq ? ecsm_pkg::UPC_DOUBLE : ecsm_pkg::UPC_CHORD;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (ui.uop)
               ecsm_pkg::U_ADD: begin
                  cmd.op = ecsm_pkg::OP_ADD;
                  upc_in = upc_ff + 1'b1;
               end
               ecsm_pkg::U_SUB: begin
                  cmd.op = ecsm_pkg::OP_SUB;
                  upc_in = upc_ff + 1'b1;
               end
               ecsm_pkg::U_MUL: begin
                  cmd.op   = ecsm_pkg::OP_MULS;
                  state_in = S_MWAIT;
               end
               ecsm_pkg::U_INV: begin
                  cmd.op   = ecsm_pkg::OP_IINIT;
                  state_in = S_ICHK;
               end
               ecsm_pkg::U_TAIL: upc_in = ecsm_pkg::UPC_TAIL;
               default: begin
                  cmd.op   = ecsm_pkg::OP_WRES;
                  state_in = S_NEXT;
               end
            endcase
         end
         S_MWAIT: begin
            if (!status.div_busy) begin
               cmd.op   = ecsm_pkg::OP_RWB;
               upc_in   = upc_ff + 1'b1;
               state_in = S_EXEC;
            end
         end
         S_ICHK: begin
            if (status.r1_zero) begin
               cmd.op   = ecsm_pkg::OP_IFIN;
               upc_in   = upc_ff + 1'b1;
               state_in = S_EXEC;
            end else begin
               cmd.op   = ecsm_pkg::OP_IDIV;
               state_in = S_IWAIT;
            end
         end
         S_IWAIT: begin
            if (!status.div_busy) begin
               cmd.op   = ecsm_pkg::OP_IMUL;
               state_in = S_IUPD;
            end
         end
         S_IUPD: begin
            cmd.op   = ecsm_pkg::OP_IUPD;
            state_in = S_ICHK;
         end
         S_NEXT: begin
            // after the add comes the doubling of the same bit
            if (add_mode_ff) begin
               add_mode_in = 1'b0;
               state_in    = S_PA;
            end else begin
               cmd.op   = ecsm_pkg::OP_SHIFTK;
               state_in = S_BIT;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = ecsm_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         upc_ff       <= '0;
         add_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         add_mode_ff  <= add_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/core/ecsm_checker.sv */
// Port-level checks for the scalar multiplier, bound to the top level.
// Depends on ecsm_pkg.
`default_nettype none

module ecsm_port_checks (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire ecsm_pkg::rsp_type  rsp_data
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_error |-> rsp_data.result_infinity)
      else $error("range error without infinity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_infinity |->
         rsp_data.result_x == '0 && rsp_data.result_y == '0)
      else $error("infinity with nonzero coordinates");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ec_point_scalar_multiply_top ecsm_port_checks u_ecsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* sim/ecsm_checker.sv */
// Checker for the scalar multiplier: tracks the CSR writes, predicts each response
// from the accepted requests and compares it as a whole. Depends on ecsm_pkg.
`default_nettype none

module ecsm_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire ecsm_pkg::req_type                   req_data,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire ecsm_pkg::rsp_type                   rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [ecsm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire ecsm_pkg::felem_type                 csr_wdata,
   output int                                       error_count,
   output int                                       pending_count
);
   import ecsm_pkg::*;

   typedef struct {
      longint unsigned x;
      longint unsigned y;
      bit              inf;
   } point_type;

   longint unsigned prime_q;
   longint unsigned coef_a;
   rsp_type         product_queue[$];

   function automatic longint unsigned mod_add(longint unsigned u, longint unsigned v,
                                               longint unsigned p);
      longint unsigned r;
      r = u + v;
      if (r >= p) r -= p;
      return r;
   endfunction

   function automatic longint unsigned mod_sub(longint unsigned u, longint unsigned v,
                                               longint unsigned p);
      return (u >= v) ? (u - v) : (u + p - v);
   endfunction

   function automatic longint unsigned mod_inv(longint unsigned u, longint unsigned m);
      longint c0, c1, r0, r1, q, t;
      if (m == 0) return 0;
      c0 = 0;
      c1 = 1;
      r0 = longint'(m);
      r1 = longint'(u % m);
      while (r1 != 0) begin
         q  = r0 / r1;
         t  = c0 - q * c1;
         c0 = c1;
         c1 = t;
         t  = r0 - q * r1;
         r0 = r1;
         r1 = t;
      end
      if (r0 != 1) return 0;
      if (c0 < 0) c0 += longint'(m);
      return longint'(c0);
   endfunction

   function automatic point_type point_sum(point_type s, point_type t, longint unsigned p,
                                           longint unsigned a);
      point_type       r;
      longint unsigned lam, num, den;
      if (s.inf) return t;
      if (t.inf) return s;
      if (s.x == t.x) begin
         if ((s.y + t.y) % p == 0) begin
            r.x   = 0;
            r.y   = 0;
            r.inf = 1;
            return r;
         end
         num = mod_add((3 * ((s.x * s.x) % p)) % p, a, p);
         den = mod_inv((2 * s.y) % p, p);
         lam = (num * den) % p;
      end else begin
         lam = (mod_sub(t.y, s.y, p) * mod_inv(mod_sub(t.x, s.x, p), p)) % p;
      end
      r.x   = mod_sub(mod_sub((lam * lam) % p, s.x, p), t.x, p);
      r.y   = mod_sub((lam * mod_sub(s.x, r.x, p)) % p, s.y, p);
      r.inf = 0;
      return r;
   endfunction

   function automatic rsp_type scalar_product(req_type rq);
      rsp_type   rs;
      point_type acc, dbl;
      longint unsigned a;
      rs  = '0;
      acc = '{0, 0, 1};
      if (!rq.point_infinity && (rq.point_x >= prime_q || rq.point_y >= prime_q)) begin
         rs.result_infinity = 1'b1;
         rs.range_error     = 1'b1;
         return rs;
      end
      if (!rq.point_infinity) begin
         a   = coef_a % prime_q;
         dbl = '{rq.point_x, rq.point_y, 0};
         for (int i = 0; i < SCALAR_BITS; i++) begin
            if (rq.scalar[i]) acc = point_sum(acc, dbl, prime_q, a);
            dbl = point_sum(dbl, dbl, prime_q, a);
         end
      end
      if (acc.inf) begin
         rs.result_infinity = 1'b1;
      end else begin
         rs.result_x = felem_type'(acc.x);
         rs.result_y = felem_type'(acc.y);
      end
      return rs;
   endfunction

   assign pending_count = product_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         prime_q = PRIME_RESET;
         coef_a  = CURVE_A_RESET;
         product_queue.delete();
         error_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FIELD_PRIME) prime_q = csr_wdata;
            else if (csr_index == CSR_CURVE_A) coef_a = csr_wdata;
         end
         if (req_valid && req_ready) product_queue.push_back(scalar_product(req_data));
         if (rsp_valid && rsp_ready) begin
            if (product_queue.size() == 0) begin
               if (error_count < 10) $display("unexpected response %p", rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = product_queue.pop_front();
               if (want !== rsp_data) begin
                  if (error_count < 10)
                     $display("response mismatch: expected %p, got %p", want, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench top for ec_point_scalar_multiply_top: drives requests, CSR phases and
// response stalls, and gives the verdict. Depends on ecsm_pkg and ecsm_checker.
`default_nettype none

module tb_top;
   import ecsm_pkg::*;

   localparam longint CYCLE_LIMIT = 20000000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_FIELD_PRIME;
   felem_type                 csr_wdata = '0;
   int                        error_count;
   int                        pending_count;
   longint                    cycle_count = 0;
   bit                        steady = 0;
   int                        stall_left = 0;
   felem_type                 prime_now = PRIME_RESET;

   always #10 clock = ~clock;

   ec_point_scalar_multiply_top u_top (.*);

   ecsm_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL ec_point_scalar_multiply_top");
         $finish;
      end
   end

   // Outside the steady phases, drop rsp_ready for a random stall after each response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall_left <= steady ? 0 : $urandom_range(0, 10);
         rsp_ready  <= steady;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(input logic [31:0] k, input felem_type x, input felem_type y,
                               input logic inf);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{k, x, y, inf};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, then hold off until every response is back.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input felem_type prime, input felem_type coef);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIELD_PRIME;
      csr_wdata <= prime;
      @(posedge clock);
      csr_index <= CSR_CURVE_A;
      csr_wdata <= coef;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      prime_now = prime;
   endtask

   task automatic random_request;
      logic [31:0] k;
      felem_type   x, y;
      int          w;
      w = ($urandom_range(0, 19) == 0) ? 32 : $urandom_range(1, 8);
      k = (w == 32) ? $urandom : ($urandom & ((32'd1 << w) - 1));
      if (prime_now != 0 && $urandom_range(0, 9) != 0) begin
         x = felem_type'($urandom % prime_now);
         y = felem_type'($urandom % prime_now);
         send_request(k, x, y, 1'b0);
      end else begin
         send_request(k, felem_type'($urandom), felem_type'($urandom),
                      logic'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      felem_type primes[6] = '{16'd65521, 16'd3, 16'd97, 16'd0, 16'd65535, 16'd9739};
      felem_type coefs[6]  = '{16'd65535, 16'd0, 16'd2, 16'd1234, 16'd7, 16'd497};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset curve, edges of each field and the special cases.
      send_request(32'd0, 16'd5, 16'd7, 1'b0);
      send_request(32'd1, 16'd5, 16'd7, 1'b0);
      send_request(32'd2, 16'd5, 16'd0, 1'b0);
      send_request(32'd3, 16'd0, 16'd0, 1'b0);
      send_request(32'd7, 16'hFFFF, 16'hFFFF, 1'b1);
      send_request(32'd5, 16'hFFFF, 16'd1, 1'b0);
      send_request(32'd5, 16'd1, 16'd9739, 1'b0);
      send_request(32'd6, 16'd9738, 16'd9738, 1'b0);
      send_request(32'hFFFF_FFFF, 16'd1234, 16'd4321, 1'b0);
      drain();
      write_csr(16'd3, 16'd0);
      send_request(32'd4, 16'd1, 16'd1, 1'b0);
      send_request(32'd9, 16'd2, 16'd2, 1'b0);
      send_request(32'd2, 16'd0, 16'd0, 1'b0);
      drain();
      write_csr(16'd15, 16'd40);
      send_request(32'd13, 16'd3, 16'd6, 1'b0);
      send_request(32'd11, 16'd5, 16'd10, 1'b0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(primes[ph], coefs[ph]);
         steady = (ph % 3 == 1);
         for (int n = 0; n < 14; n++) random_request();
         drain();
      end

      if (error_count == 0) begin
         $display("PASS ec_point_scalar_multiply_top");
      end else begin
         $display("FAIL ec_point_scalar_multiply_top");
      end
      $finish;
   end

endmodule

`default_nettype wire
